>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the event timer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge outside reset.
`define ETCB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define ETCB_ASSERT_IMP(label, cond, cons, msg) \
    `ETCB_ASSERT(label, (cond) |-> (cons), msg)

`endif

>>> src/etcb_pkg.sv
// ----------------------------------------------------------------------------
// Event timer package
// Types and constants shared by the event timer front, queue and back.
// ----------------------------------------------------------------------------
package etcb_pkg;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    localparam logic [9:0] ADDR_CAPS        = 10'h000;
    localparam logic [9:0] ADDR_GCONF       = 10'h010;
    localparam logic [9:0] ADDR_STATUS      = 10'h020;
    localparam logic [9:0] ADDR_COUNTER     = 10'h0F0;
    localparam logic [9:0] ADDR_TIMER_BASE  = 10'h100;
    localparam logic [4:0] SUB_CONFIG       = 5'h00;
    localparam logic [4:0] SUB_COMPARE      = 5'h08;

    localparam int BIT_INT_EN   = 2;
    localparam int BIT_PERIODIC = 3;
    localparam int BIT_PER_CAP  = 4;
    localparam int ROUTE_LSB    = 9;
    localparam int ROUTE_W      = 5;
    localparam int IRQ_W        = 3;

    localparam logic CFG_TICK_PERIOD = 1'b0;
    localparam logic CFG_ROUTE_MASK  = 1'b1;

    localparam logic [26:0] TICK_PERIOD_RESET = 27'd69841279;
    localparam logic [31:0] ROUTE_MASK_RESET  = 32'd15728640;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_TICK,
        OP_READ,
        OP_WRITE
    } t_op;

    typedef enum logic [2:0] {
        REG_CAPS,
        REG_GCONF,
        REG_STATUS,
        REG_COUNTER,
        REG_TCONF,
        REG_TCMP,
        REG_BAD
    } t_reg;

    typedef struct packed {
        t_op         op;
        t_reg        regsel;
        logic [4:0]  timer;
        logic [63:0] data;
    } t_item;

endpackage

>>> src/etcb_front.sv
// ----------------------------------------------------------------------------
// Event timer front end
// Classifies each accepted word into an operation and a decoded register.
// ----------------------------------------------------------------------------
module etcb_front import etcb_pkg::*; #(
    parameter int NUM_TIMERS = 3
) (
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_address,
    input  logic [63:0] i_write_data,
    output t_item       o_item
);

    logic [9:0] w_off;
    logic [4:0] w_tn;
    logic [4:0] w_sub;
    logic       w_tvalid;
    t_reg       w_reg;

    assign w_off    = i_address - ADDR_TIMER_BASE;
    assign w_tn     = w_off[9:5];
    assign w_sub    = w_off[4:0];
    assign w_tvalid = (i_address >= ADDR_TIMER_BASE) && ({1'b0, w_tn} < 6'(NUM_TIMERS));

    always_comb begin
        if (i_address == ADDR_CAPS) begin
            w_reg = REG_CAPS;
        end else if (i_address == ADDR_GCONF) begin
            w_reg = REG_GCONF;
        end else if (i_address == ADDR_STATUS) begin
            w_reg = REG_STATUS;
        end else if (i_address == ADDR_COUNTER) begin
            w_reg = REG_COUNTER;
        end else if (w_tvalid && w_sub == SUB_CONFIG) begin
            w_reg = REG_TCONF;
        end else if (w_tvalid && w_sub == SUB_COMPARE) begin
            w_reg = REG_TCMP;
        end else begin
            w_reg = REG_BAD;
        end
    end

    always_comb begin
        o_item.regsel = w_reg;
        o_item.timer  = w_tn;
        o_item.data   = i_write_data;
        unique case (i_command)
            CMD_TICK:  o_item.op = OP_TICK;
            CMD_READ:  o_item.op = OP_READ;
            CMD_WRITE: o_item.op = OP_WRITE;
            default:   o_item.op = OP_NONE;
        endcase
    end

endmodule

>>> src/etcb_queue.sv
// ----------------------------------------------------------------------------
// Event timer queue
// Two-entry queue that decouples the front end from the execution back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etcb_queue import etcb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_nempty,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       n_wptr;
    logic       n_rptr;
    logic [1:0] n_count;
    logic       w_push;
    logic       w_pop;

    assign o_full   = (r_count == 2'd2);
    assign o_nempty = (r_count != 2'd0);
    assign o_item   = r_mem[r_rptr];
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_nempty;

    always_comb begin
        n_wptr  = w_push ? !r_wptr : r_wptr;
        n_rptr  = w_pop ? !r_rptr : r_rptr;
        n_count = r_count + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    `ETCB_ASSERT(a_count_bound, r_count <= 2'd2, "queue count exceeds depth")
    `ETCB_ASSERT_IMP(a_count_step, w_push && !w_pop, r_count != 2'd2, "push into full queue")
    `ETCB_ASSERT(a_ptr_gap, (r_count == 2'd1) == (r_wptr != r_rptr), "pointers disagree with count")

endmodule

>>> src/etcb_back.sv
// ----------------------------------------------------------------------------
// Event timer back end
// Holds the counter and timer state, executes each word, registers results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module etcb_back import etcb_pkg::*; #(
    parameter int NUM_TIMERS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_nempty,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [26:0] i_tick_period,
    input  logic [31:0] i_route_mask,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_read_data,
    output logic [IRQ_W-1:0] o_irq_lines,
    output logic        o_access_error
);

    logic [63:0]          r_count;
    logic                 r_cnt_en;
    logic [NUM_TIMERS-1:0] r_pend;
    logic [NUM_TIMERS-1:0] r_ien;
    logic [NUM_TIMERS-1:0] r_per;
    logic [ROUTE_W-1:0]   r_route  [NUM_TIMERS];
    logic [63:0]          r_match  [NUM_TIMERS];
    logic [63:0]          r_period [NUM_TIMERS];
    logic                 r_out_valid;
    logic [63:0]          r_rdata;
    logic [IRQ_W-1:0]     r_irq;
    logic                 r_err;

    logic [63:0]          n_count;
    logic                 n_cnt_en;
    logic [NUM_TIMERS-1:0] n_pend;
    logic [NUM_TIMERS-1:0] n_ien;
    logic [NUM_TIMERS-1:0] n_per;
    logic [ROUTE_W-1:0]   n_route  [NUM_TIMERS];
    logic [63:0]          n_match  [NUM_TIMERS];
    logic [63:0]          n_period [NUM_TIMERS];
    logic [63:0]          n_rdata;
    logic                 n_err;

    logic                 w_fire;
    logic                 w_tick;
    logic                 w_rd;
    logic                 w_wr;
    logic [63:0]          w_inc;
    logic [63:0]          w_tconf;
    logic [63:0]          w_tcmp;
    logic [63:0]          w_status;
    logic [NUM_TIMERS-1:0] w_sel;

    assign w_fire = i_nempty && (!r_out_valid || !i_out_stall);
    assign o_pop  = w_fire;
    assign w_tick = w_fire && (i_item.op == OP_TICK) && r_cnt_en;
    assign w_rd   = w_fire && (i_item.op == OP_READ);
    assign w_wr   = w_fire && (i_item.op == OP_WRITE);
    assign w_inc  = r_count + 64'd1;

    always_comb begin
        w_tconf  = '0;
        w_tcmp   = '0;
        w_status = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            w_sel[i]    = (i_item.timer == 5'(i));
            w_status[i] = r_pend[i];
            if (w_sel[i]) begin
                w_tconf = {i_route_mask, 18'd0, r_route[i], 4'd0, 1'b1, r_per[i],
                           r_ien[i], 2'd0};
                w_tcmp  = r_match[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_cnt_en = r_cnt_en;
        n_rdata  = '0;
        n_err    = 1'b0;
        if (w_tick) begin
            n_count = w_inc;
        end
        if (w_wr && i_item.regsel == REG_GCONF) begin
            n_cnt_en = i_item.data[0];
        end
        if (w_wr && i_item.regsel == REG_COUNTER) begin
            n_count = i_item.data;
        end
        if ((w_rd || w_wr) && i_item.regsel == REG_BAD) begin
            n_err = 1'b1;
        end
        if (w_rd) begin
            unique case (i_item.regsel)
                REG_CAPS:    n_rdata = {5'd0, i_tick_period, 19'd0,
                                        5'(NUM_TIMERS - 1), 8'd0};
                REG_GCONF:   n_rdata = {63'd0, r_cnt_en};
                REG_STATUS:  n_rdata = w_status;
                REG_COUNTER: n_rdata = r_count;
                REG_TCONF:   n_rdata = w_tconf;
                REG_TCMP:    n_rdata = w_tcmp;
                default:     n_rdata = '0;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            n_pend[i]   = r_pend[i];
            n_ien[i]    = r_ien[i];
            n_per[i]    = r_per[i];
            n_route[i]  = r_route[i];
            n_match[i]  = r_match[i];
            n_period[i] = r_period[i];
            if (w_tick && r_match[i] == w_inc) begin
                n_pend[i] = 1'b1;
                if (r_per[i]) begin
                    n_match[i] = r_match[i] + r_period[i];
                end
            end
            if (w_wr && i_item.regsel == REG_STATUS && i_item.data[i]) begin
                n_pend[i] = 1'b0;
            end
            if (w_wr && i_item.regsel == REG_TCONF && w_sel[i]) begin
                n_ien[i]   = i_item.data[BIT_INT_EN];
                n_per[i]   = i_item.data[BIT_PERIODIC];
                n_route[i] = i_item.data[ROUTE_LSB +: ROUTE_W];
            end
            if (w_wr && i_item.regsel == REG_TCMP && w_sel[i]) begin
                n_match[i] = i_item.data;
                if (r_per[i]) begin
                    n_period[i] = i_item.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cnt_en    <= 1'b0;
            r_pend      <= '0;
            r_ien       <= '0;
            r_per       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_route[i]  <= '0;
                r_match[i]  <= '1;
                r_period[i] <= '0;
            end
        end else begin
            r_count  <= n_count;
            r_cnt_en <= n_cnt_en;
            r_pend   <= n_pend;
            r_ien    <= n_ien;
            r_per    <= n_per;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                r_route[i]  <= n_route[i];
                r_match[i]  <= n_match[i];
                r_period[i] <= n_period[i];
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rdata <= n_rdata;
            r_irq   <= n_pend[IRQ_W-1:0] & n_ien[IRQ_W-1:0];
            r_err   <= n_err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_read_data    = r_rdata;
    assign o_irq_lines    = r_irq;
    assign o_access_error = r_err;

    `ETCB_ASSERT_IMP(a_err_zero, r_out_valid && r_err, r_rdata == 64'd0, "error result carries data")
    `ETCB_ASSERT_IMP(a_no_overrun, r_out_valid && i_out_stall, !w_fire, "result overwritten while stalled")
    `ETCB_ASSERT_IMP(a_irq_enabled, r_out_valid && !i_out_stall && !w_fire,
        (r_irq & ~r_ien[IRQ_W-1:0]) == '0, "irq line without enable")

endmodule

>>> src/event_timer_comparator_bank_unit.sv
// ----------------------------------------------------------------------------
// Event timer comparator bank
// High precision event timer with a main counter and per-timer comparators.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle unless o_in_stall is high, whether
// a tick, a register read or a register write, and returns one result word
// for each, in order. A word passes the decoder into a two-entry queue and is
// executed from there by the back end, whose counter increment and comparator
// match set the rate of one word per cycle while the output is not stalled; a
// result waits in an output register while the output is stalled.
// Configuration writes have a port of their own and are always taken.
module event_timer_comparator_bank_unit import etcb_pkg::*; #(
    parameter int NUM_TIMERS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_address,
    input  logic [63:0] i_write_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_read_data,
    output logic [2:0]  o_irq_lines,
    output logic        o_access_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [26:0] r_tick_period;
    logic [31:0] r_route_mask;
    t_item       w_in_item;
    t_item       w_q_item;
    logic        w_full;
    logic        w_nempty;
    logic        w_pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = w_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_period <= TICK_PERIOD_RESET;
            r_route_mask  <= ROUTE_MASK_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICK_PERIOD: r_tick_period <= i_cfg_data[26:0];
                CFG_ROUTE_MASK:  r_route_mask  <= i_cfg_data;
                default:         r_route_mask  <= r_route_mask;
            endcase
        end
    end

    etcb_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .i_command    (i_command),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_item       (w_in_item)
    );

    etcb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_in_valid),
        .i_item   (w_in_item),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_nempty (w_nempty),
        .o_item   (w_q_item)
    );

    etcb_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_nempty       (w_nempty),
        .i_item         (w_q_item),
        .o_pop          (w_pop),
        .i_tick_period  (r_tick_period),
        .i_route_mask   (r_route_mask),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_read_data    (o_read_data),
        .o_irq_lines    (o_irq_lines),
        .o_access_error (o_access_error)
    );

endmodule

>>> tb/event_timer_comparator_bank_unit_checker.sv
// ----------------------------------------------------------------------------
// Event timer result checker
// Watches the input, configuration and result channels of the event timer,
// keeps its own copy of the counter, comparators and registers, and compares
// every result word field by field with the oldest predicted word.
// ----------------------------------------------------------------------------
module event_timer_comparator_bank_unit_checker import etcb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_command,
    input  logic [9:0]  i_address,
    input  logic [63:0] i_write_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_read_data,
    input  logic [2:0]  i_irq_lines,
    input  logic        i_access_error,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NT = 3;

    typedef struct packed {
        logic [63:0] read_data;
        logic [2:0]  irq_lines;
        logic        access_error;
    } t_result;

    t_result     expected_words[$];
    logic [26:0] tick_period;
    logic [31:0] route_mask;
    logic [63:0] main_count;
    logic        count_en;
    logic        status[NT];
    logic        int_en[NT];
    logic        periodic[NT];
    logic [4:0]  route[NT];
    logic [63:0] compare[NT];
    logic [63:0] period[NT];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = expected_words.size();

    function automatic logic [2:0] irq_now();
        logic [2:0] v;
        v = '0;
        for (int i = 0; i < NT && i < IRQ_W; i++) v[i] = status[i] & int_en[i];
        return v;
    endfunction

    task automatic timer_predict(input logic [1:0] cmd, input logic [9:0] addr,
                                 input logic [63:0] data);
        t_result     r;
        logic        wr;
        logic [9:0]  off;
        int          n;
        logic [4:0]  sub;
        r  = '0;
        wr = (cmd == CMD_WRITE);
        if (cmd == CMD_TICK) begin
            if (count_en) begin
                main_count = main_count + 64'd1;
                for (int i = 0; i < NT; i++) begin
                    if (main_count == compare[i]) begin
                        status[i] = 1'b1;
                        if (periodic[i]) compare[i] = compare[i] + period[i];
                    end
                end
            end
        end else if (cmd == CMD_READ || cmd == CMD_WRITE) begin
            if (addr == ADDR_CAPS) begin
                if (!wr) r.read_data = {5'd0, tick_period, 19'd0, 5'(NT - 1), 8'd0};
            end else if (addr == ADDR_GCONF) begin
                if (wr) count_en = data[0];
                else r.read_data = {63'd0, count_en};
            end else if (addr == ADDR_STATUS) begin
                if (wr) begin
                    for (int i = 0; i < NT; i++) if (data[i]) status[i] = 1'b0;
                end else begin
                    for (int i = 0; i < NT; i++) r.read_data[i] = status[i];
                end
            end else if (addr == ADDR_COUNTER) begin
                if (wr) main_count = data;
                else r.read_data = main_count;
            end else if (addr < ADDR_TIMER_BASE) begin
                r.access_error = 1'b1;
            end else begin
                off = addr - ADDR_TIMER_BASE;
                n   = int'(off >> 5);
                sub = off[4:0];
                if (n >= NT) begin
                    r.access_error = 1'b1;
                end else if (sub == SUB_CONFIG) begin
                    if (wr) begin
                        int_en[n]   = data[BIT_INT_EN];
                        periodic[n] = data[BIT_PERIODIC];
                        route[n]    = data[ROUTE_LSB +: ROUTE_W];
                    end else begin
                        r.read_data = {route_mask, 18'd0, route[n], 4'd0,
                                       1'b1, periodic[n], int_en[n], 2'd0};
                    end
                end else if (sub == SUB_COMPARE) begin
                    if (wr) begin
                        compare[n] = data;
                        if (periodic[n]) period[n] = data;
                    end else begin
                        r.read_data = compare[n];
                    end
                end else begin
                    r.access_error = 1'b1;
                end
            end
        end
        r.irq_lines = irq_now();
        expected_words.push_back(r);
    endtask

    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            expected_words.delete();
            tick_period = TICK_PERIOD_RESET;
            route_mask  = ROUTE_MASK_RESET;
            main_count  = '0;
            count_en    = 1'b0;
            fails       = 0;
            for (int i = 0; i < NT; i++) begin
                status[i] = 1'b0; int_en[i] = 1'b0; periodic[i] = 1'b0; route[i] = '0;
                compare[i] = '1; period[i] = '0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_TICK_PERIOD) tick_period = i_cfg_data[26:0];
                else route_mask = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_words.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("Unexpected result word %h %h %b",
                                              i_read_data, i_irq_lines, i_access_error);
                end else begin
                    e = expected_words.pop_front();
                    if (e.read_data !== i_read_data || e.irq_lines !== i_irq_lines ||
                        e.access_error !== i_access_error) begin
                        fails++;
                        if (fails <= 10)
                            $display("Mismatch: expected %h %h %b, actual %h %h %b",
                                     e.read_data, e.irq_lines, e.access_error,
                                     i_read_data, i_irq_lines, i_access_error);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) timer_predict(i_command, i_address, i_write_data);
        end
    end
endmodule

>>> tb/event_timer_comparator_bank_unit_tb.sv
// ----------------------------------------------------------------------------
// Event timer testbench
// Drives directed and random ticks, reads and writes into the event timer
// under several idle and stall patterns, changes the configuration between
// phases and reports the checker's verdict.
// ----------------------------------------------------------------------------
module event_timer_comparator_bank_unit_tb;
    import etcb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_command;
    logic [9:0]  i_address;
    logic [63:0] i_write_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_read_data;
    logic [2:0]  o_irq_lines;
    logic        o_access_error;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [31:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_stall_pct;

    event_timer_comparator_bank_unit u_top (.*);

    event_timer_comparator_bank_unit_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_in_stall(o_in_stall), .i_command(i_command), .i_address(i_address),
        .i_write_data(i_write_data), .i_out_valid(o_out_valid),
        .i_out_stall(i_out_stall), .i_read_data(o_read_data),
        .i_irq_lines(o_irq_lines), .i_access_error(o_access_error),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_word(input logic [1:0] cmd, input logic [9:0] addr,
                             input logic [63:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic drain_and_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        logic [63:0] v;
        case ($urandom_range(5))
            0: v = '0;
            1: v = '1;
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    function automatic logic [9:0] good_addr();
        logic [9:0] a;
        case ($urandom_range(6))
            0: a = ADDR_CAPS;
            1: a = ADDR_GCONF;
            2: a = ADDR_STATUS;
            3: a = ADDR_COUNTER;
            default: a = ADDR_TIMER_BASE + 10'($urandom_range(2) * 32)
                         + ($urandom_range(1) ? 10'(SUB_COMPARE) : 10'(SUB_CONFIG));
        endcase
        return a;
    endfunction

    task automatic random_word();
        logic [1:0]  cmd;
        logic [9:0]  addr;
        logic [63:0] data;
        logic [63:0] near;
        int          k;
        k    = $urandom_range(99);
        addr = good_addr();
        data = rand64();
        near = 64'($urandom_range(12));
        if (k < 45) cmd = CMD_TICK;
        else if (k < 65) cmd = CMD_READ;
        else cmd = CMD_WRITE;
        if (k >= 95) begin
            addr = 10'($urandom);
            cmd  = 2'($urandom);
        end
        if (cmd == CMD_WRITE && addr == ADDR_GCONF && $urandom_range(3) != 0) data[0] = 1'b1;
        if (cmd == CMD_WRITE && addr[4:0] == SUB_COMPARE && addr >= ADDR_TIMER_BASE)
            data = $urandom_range(1) ? near : rand64();
        if (cmd == CMD_WRITE && addr == ADDR_COUNTER && $urandom_range(1))
            data = $urandom_range(1) ? '0 : 64'hFFFF_FFFF_FFFF_FFF8 + near;
        send_word(cmd, addr, data);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_TICK;
        i_address      = '0;
        i_write_data   = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_TICK_PERIOD;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_word(CMD_READ, ADDR_CAPS, '0);
        send_word(CMD_WRITE, ADDR_CAPS, '1);
        send_word(CMD_READ, 10'h108, '0);
        send_word(CMD_READ, 10'h100, '0);
        send_word(CMD_WRITE, 10'h100, 64'h3E0C);
        send_word(CMD_WRITE, 10'h108, 64'd2);
        send_word(CMD_WRITE, 10'h120, 64'h4);
        send_word(CMD_WRITE, 10'h128, 64'd3);
        send_word(CMD_WRITE, ADDR_COUNTER, '0);
        send_word(CMD_WRITE, ADDR_GCONF, 64'd1);
        repeat (6) send_word(CMD_TICK, '0, '0);
        send_word(CMD_READ, ADDR_STATUS, '0);
        send_word(CMD_WRITE, ADDR_STATUS, '1);
        send_word(CMD_WRITE, 10'h148, '1);
        send_word(CMD_WRITE, ADDR_COUNTER, 64'hFFFF_FFFF_FFFF_FFFE);
        send_word(CMD_TICK, '0, '0);
        send_word(CMD_READ, 10'h160, '0);
        send_word(CMD_WRITE, 10'h104, '1);
        send_word(CMD_READ, 10'h011, '0);
        send_word(2'd3, 10'h3FF, '1);
        drain_and_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin write_cfg(CFG_TICK_PERIOD, 32'd1);
                         write_cfg(CFG_ROUTE_MASK, 32'd0); end
                1: begin write_cfg(CFG_TICK_PERIOD, 32'd100000000);
                         write_cfg(CFG_ROUTE_MASK, 32'hFFFF_FFFF); end
                default: begin write_cfg(CFG_TICK_PERIOD, $urandom_range(100000000, 1));
                         write_cfg(CFG_ROUTE_MASK, $urandom); end
            endcase
            i_cfg_valid <= 1'b0;
            send_idle_pct  = (ph == 1 || ph == 3) ? 73 : (ph == 4 ? 11 : 0);
            recv_stall_pct = (ph == 2 || ph == 3) ? 73 : (ph == 4 ? 11 : 0);
            repeat (250) random_word();
            drain_and_idle();
        end

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
